// ----- rtl/core/msra_pkg.sv -----
// shared constants, phase codes and helpers for the step response autotune block
// no dependencies
package msra_pkg;

	localparam int CountWidthDefault = 32;
	localparam int DivWidth          = 64;
	localparam int OutBits           = 200;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BASE = 3'd1;
	localparam logic [2:0] PH_STEP = 3'd2;
	localparam logic [2:0] PH_OBS  = 3'd3;
	localparam logic [2:0] PH_FIN  = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;

	localparam logic [2:0] REG_TPR  = 3'd0;
	localparam logic [2:0] REG_SMS  = 3'd1;
	localparam logic [2:0] REG_BASE = 3'd2;
	localparam logic [2:0] REG_OBS  = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;
	localparam logic [2:0] REG_DSLO = 3'd5;
	localparam logic [2:0] REG_DMED = 3'd6;
	localparam logic [2:0] REG_DHI  = 3'd7;

	localparam logic [1:0] MODE_SLOW = 2'd0;
	localparam logic [1:0] MODE_MED  = 2'd1;

	localparam logic [15:0] IDLE_LIMIT_MS = 16'd2000;

	function automatic logic [15:0] sat16_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [31:0] cap32(input logic [DivWidth-1:0] v);
		return (v > {{(DivWidth-32){1'b0}}, 32'hFFFF_FFFF}) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

// ----- rtl/core/msra_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on msra_pkg
module msra_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [msra_pkg::DivWidth-1:0]  dividend,
	input  logic [msra_pkg::DivWidth-1:0]  divisor,
	output logic [msra_pkg::DivWidth-1:0]  quotient,
	output logic                           busy,
	output logic                           done
);
	import msra_pkg::*;

	localparam int CntW = $clog2(DivWidth);

	logic [DivWidth-1:0] rem_q, quo_q, dvs_q;
	logic [CntW-1:0]     cnt_q;
	logic                busy_q, done_q;
	logic [DivWidth:0]   trial;
	logic                fits;

	assign trial = {rem_q, quo_q[DivWidth-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivWidth - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DivWidth'(trial - {1'b0, dvs_q}) : trial[DivWidth-1:0];
			quo_q <= {quo_q[DivWidth-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("divider done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("divider did not start");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("divider done held");

endmodule

// ----- rtl/core/motor_step_response_autotune_top.sv -----
// Step response autotune: one encoder count word in, one result word out per sample.
// Each word goes through a small sequencer that shares one 64-bit restoring divider.
// An observe sample adds an averaging division, the sample that closes the observation
// may add a gain division as well, and the finished sample runs up to four divisions.
// The input is not ready while a word is in work; a result waits in the output register.
// depends on msra_pkg and msra_div
module motor_step_response_autotune_top #(
	parameter int COUNT_WIDTH = msra_pkg::CountWidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // encoder_count
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// drive_duty, speed_rps, phase_code, result_valid, motor_off, plant_gain,
	// time_constant_ms, feedforward_gain, proportional_gain, integral_gain, zero pad
	output logic [msra_pkg::OutBits-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_addr,
	input  logic [15:0]                   cfg_data
);
	import msra_pkg::*;

	localparam int DW = DivWidth;

	typedef enum logic [3:0] {
		S_IDLE, S_SPD0, S_SPD1, S_SPDW, S_PH, S_AVG0, S_AVGW, S_TAU, S_GW,
		S_FFW, S_KPW, S_KIS, S_KIW, S_PUSH
	} state_t;

	state_t st_q;

	logic [15:0] tpr_q, base_q, obs_q, dslo_q, dmed_q, dhi_q;
	logic [9:0]  sms_q;
	logic [1:0]  mode_q;

	logic [2:0]             phase_q;
	logic [15:0]            pt_q, it_q, total_q, step_q, since_q, tau_q;
	logic [31:0]            gain_q;
	logic [COUNT_WIDTH-1:0] prev_q, mag_q;
	logic                   neg_q;
	logic signed [47:0]     sum_q;
	logic [25:0]            den_q;
	logic [DW-1:0]          num_q, kpx_q;
	logic signed [31:0]     speed_q, avg_q;

	logic [15:0] drive_q, tauo_q;
	logic [2:0]  shown_q;
	logic        res_q, off_q;
	logic [31:0] kg_q, ff_q, kp_q, ki_q;
	logic        m_valid_q;
	logic [OutBits-1:0] m_data_q;

	logic          dv_start_q;
	logic [DW-1:0] dv_a_q, dv_b_q, dv_quo;
	logic          dv_busy, dv_done;

	msra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start_q),
		.dividend (dv_a_q),
		.divisor  (dv_b_q),
		.quotient (dv_quo),
		.busy     (dv_busy),
		.done     (dv_done)
	);

	logic [COUNT_WIDTH-1:0] now_w, diff_w;
	logic [15:0]            sms16, it_add, pt_add, since_add, total_add;
	logic signed [48:0]     sum_add;
	logic signed [47:0]     sum_sat;
	logic [DW-1:0]          mag64, sum_abs;
	logic signed [63:0]     lhs, rhs, sp64, av64;
	logic                   sum_neg;

	assign now_w     = s_tdata[COUNT_WIDTH-1:0];
	assign diff_w    = now_w - prev_q;
	assign sms16     = {6'd0, sms_q};
	assign it_add    = sat16_add(it_q, sms16);
	assign pt_add    = sat16_add(pt_q, sms16);
	assign since_add = sat16_add(since_q, sms16);
	assign total_add = sat16_add(total_q, 16'd1);
	assign sum_add   = {sum_q[47], sum_q} + 49'(speed_q);
	assign sum_sat   = (sum_add > 49'sd140737488355327) ? 48'sh7FFF_FFFF_FFFF :
		(sum_add < -49'sd140737488355328) ? 48'sh8000_0000_0000 : sum_add[47:0];
	assign mag64     = DW'(mag_q);
	assign sum_neg   = sum_q[47];
	assign sum_abs   = sum_neg ? DW'(-{sum_q[47], sum_q}) : DW'(sum_q);
	assign sp64      = 64'(speed_q);
	assign av64      = 64'(avg_q);
	assign lhs       = (sp64 <<< 10) - (sp64 <<< 4) - (sp64 <<< 3);
	assign rhs       = (av64 <<< 9) + (av64 <<< 7) - (av64 <<< 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpr_q  <= 16'd1;
			sms_q  <= 10'd10;
			base_q <= 16'd1000;
			obs_q  <= 16'd2000;
			mode_q <= 2'd2;
			dslo_q <= '0;
			dmed_q <= '0;
			dhi_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TPR:  tpr_q  <= cfg_data;
				REG_SMS:  sms_q  <= cfg_data[9:0];
				REG_BASE: base_q <= cfg_data;
				REG_OBS:  obs_q  <= cfg_data;
				REG_MODE: mode_q <= cfg_data[1:0];
				REG_DSLO: dslo_q <= cfg_data;
				REG_DMED: dmed_q <= cfg_data;
				REG_DHI:  dhi_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			phase_q    <= PH_IDLE;
			pt_q       <= '0;
			it_q       <= '0;
			prev_q     <= '0;
			sum_q      <= '0;
			total_q    <= '0;
			step_q     <= '0;
			since_q    <= '0;
			tau_q      <= '0;
			gain_q     <= '0;
			dv_start_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			dv_start_q <= 1'b0;
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (s_tvalid) begin
						prev_q <= now_w;
						neg_q  <= diff_w[COUNT_WIDTH-1];
						mag_q  <= diff_w[COUNT_WIDTH-1] ? -diff_w : diff_w;
						st_q   <= S_SPD0;
					end
				end
				S_SPD0: begin
					den_q <= 26'(tpr_q) * 26'(sms_q);
					num_q <= ((mag64 << 10) - (mag64 << 4) - (mag64 << 3)) << 16;
					st_q  <= S_SPD1;
				end
				S_SPD1: begin
					if (mag_q == '0) begin
						speed_q <= '0;
						st_q    <= S_PH;
					end else if (den_q == '0) begin
						speed_q <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
						st_q    <= S_PH;
					end else begin
						dv_a_q     <= num_q;
						dv_b_q     <= DW'(den_q);
						dv_start_q <= 1'b1;
						st_q       <= S_SPDW;
					end
				end
				S_SPDW: begin
					if (dv_done) begin
						if (neg_q)
							speed_q <= (dv_quo >= DW'(64'h8000_0000)) ? 32'sh8000_0000 :
								-dv_quo[31:0];
						else
							speed_q <= (dv_quo > DW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF :
								dv_quo[31:0];
						st_q <= S_PH;
					end
				end
				S_PH: begin
					shown_q <= phase_q;
					drive_q <= '0;
					res_q   <= 1'b0;
					off_q   <= 1'b0;
					kg_q    <= '0;
					tauo_q  <= '0;
					ff_q    <= '0;
					kp_q    <= '0;
					ki_q    <= '0;
					st_q    <= S_PUSH;
					unique case (phase_q)
						PH_IDLE: begin
							pt_q <= '0;
							if (it_add >= IDLE_LIMIT_MS) begin
								it_q    <= '0;
								phase_q <= PH_BASE;
							end else begin
								it_q <= it_add;
							end
						end
						PH_BASE: begin
							sum_q   <= '0;
							total_q <= '0;
							tau_q   <= '0;
							gain_q  <= '0;
							since_q <= '0;
							if (pt_add >= base_q) begin
								pt_q    <= '0;
								phase_q <= PH_STEP;
							end else begin
								pt_q <= pt_add;
							end
						end
						PH_STEP: begin
							case (mode_q)
								MODE_SLOW: begin
									step_q  <= dslo_q;
									drive_q <= dslo_q;
								end
								MODE_MED: begin
									step_q  <= dmed_q;
									drive_q <= dmed_q;
								end
								default: begin
									step_q  <= dhi_q;
									drive_q <= dhi_q;
								end
							endcase
							since_q <= '0;
							phase_q <= PH_OBS;
						end
						PH_OBS: begin
							drive_q <= step_q;
							pt_q    <= pt_add;
							since_q <= since_add;
							sum_q   <= sum_sat;
							total_q <= total_add;
							st_q    <= S_AVG0;
						end
						PH_FIN: begin
							kg_q    <= gain_q;
							tauo_q  <= tau_q;
							res_q   <= 1'b1;
							off_q   <= 1'b1;
							pt_q    <= '0;
							phase_q <= PH_END;
							if (gain_q == '0) begin
								ff_q <= 32'hFFFF_FFFF;
								kp_q <= 32'hFFFF_FFFF;
								ki_q <= 32'hFFFF_FFFF;
							end else begin
								dv_a_q     <= DW'(64'h1_0000_0000);
								dv_b_q     <= DW'(gain_q);
								dv_start_q <= 1'b1;
								st_q       <= S_FFW;
							end
						end
						default: begin
							off_q   <= 1'b1;
							phase_q <= PH_END;
							shown_q <= PH_END;
						end
					endcase
				end
				S_AVG0: begin
					dv_a_q     <= sum_abs;
					dv_b_q     <= DW'(total_q);
					dv_start_q <= 1'b1;
					st_q       <= S_AVGW;
				end
				S_AVGW: begin
					if (dv_done) begin
						if (sum_neg)
							avg_q <= (dv_quo >= DW'(64'h8000_0000)) ? 32'sh8000_0000 :
								-dv_quo[31:0];
						else
							avg_q <= (dv_quo > DW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF :
								dv_quo[31:0];
						st_q <= S_TAU;
					end
				end
				S_TAU: begin
					st_q <= S_PUSH;
					if (tau_q == '0 && lhs >= rhs)
						tau_q <= since_q;
					if (pt_q >= obs_q) begin
						if (avg_q <= 0 || step_q == '0) begin
							gain_q  <= (avg_q <= 0) ? 32'd0 : 32'hFFFF_FFFF;
							phase_q <= PH_FIN;
							pt_q    <= '0;
						end else begin
							dv_a_q     <= DW'(avg_q) << 8;
							dv_b_q     <= DW'(step_q);
							dv_start_q <= 1'b1;
							st_q       <= S_GW;
						end
					end
				end
				S_GW: begin
					if (dv_done) begin
						gain_q  <= cap32(dv_quo);
						phase_q <= PH_FIN;
						pt_q    <= '0;
						st_q    <= S_PUSH;
					end
				end
				S_FFW: begin
					if (dv_done) begin
						ff_q       <= cap32(dv_quo);
						dv_a_q     <= DW'(tau_q) << 32;
						dv_b_q     <= (DW'(gain_q) << 6) + (DW'(gain_q) << 5) + (DW'(gain_q) << 2);
						dv_start_q <= 1'b1;
						st_q       <= S_KPW;
					end
				end
				S_KPW: begin
					if (dv_done) begin
						kpx_q <= dv_quo;
						kp_q  <= cap32(dv_quo);
						if (tau_q == '0) begin
							ki_q <= 32'hFFFF_FFFF;
							st_q <= S_PUSH;
						end else begin
							st_q <= S_KIS;
						end
					end
				end
				S_KIS: begin
					dv_a_q     <= (kpx_q << 8) - (kpx_q << 2) - (kpx_q << 1);
					dv_b_q     <= DW'(tau_q);
					dv_start_q <= 1'b1;
					st_q       <= S_KIW;
				end
				S_KIW: begin
					if (dv_done) begin
						ki_q <= cap32(dv_quo);
						st_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {3'd0, ki_q, kp_q, ff_q, tauo_q, kg_q, off_q, res_q,
							shown_q, speed_q, drive_q};
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> !dv_busy) else $error("divider busy while idle");
	a_push_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(st_q == S_PUSH)) else $error("word from wrong state");
	a_res_off: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_PUSH && res_q) |-> (off_q && drive_q == '0)) else $error("drive on result");

endmodule
